// ----- design/arpm_pkg.sv -----
// shared types, widths and register codes for the audio rms and peak meter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package arpm_pkg;

    localparam int MAG_W      = 16;                 // sample and magnitude width
    localparam int COUNT_W    = 24;                 // sample counter width
    localparam int SQ_W       = 2 * MAG_W - 1;      // square of a magnitude, also the mean
    localparam int SUM_W      = SQ_W - 1 + COUNT_W; // sum of squares
    localparam int RT_W       = (SQ_W + 1) / 2;     // square root of the mean
    localparam int SEEN_W     = 24;                 // samples_seen field
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_RMS_THR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_THR = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0] RMS_THR_RESET  = THR_W'(656);
    localparam logic [THR_W-1:0] PEAK_THR_RESET = THR_W'(2622);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic signed [MAG_W-1:0] sample;
    } t_in;

    typedef struct packed {
        logic [RT_W-1:0]   rms_level;
        logic [MAG_W-1:0]  peak_out;
        logic [SEEN_W-1:0] samples_seen;
        logic              active;
        logic              count_overflow;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_DIVIDE,
        S_ROOT,
        S_EMIT
    } t_state;

endpackage

// ----- design/audio_rms_peak_meter.sv -----
// top level of the audio rms and peak meter: control, accumulators, output register
// depends on arpm_pkg, arpm_squarer, arpm_divider, arpm_isqrt
//
//   channel   direction  handshake                      payload
//   input     in         i_in_valid / o_in_stall        i_in_data   (t_in)
//   output    out        o_out_valid / i_out_stall      o_out_data  (t_out)
//   config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// a sample passes through the squarer, which walks the 16 magnitude bits one per cycle
// a sample arriving with the counter saturated skips the squarer (peak and overflow only)
// a report passes through the bit-serial divider and then the square root
// a report with no samples goes straight back to idle and only clears the accumulators
// reset is synchronous and active low; thresholds return to 656 and 2622
// a stalled result sits in the output register while the next transaction is accepted
`timescale 1ns / 1ps

module audio_rms_peak_meter
    import arpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // accumulators
    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;
    logic [MAG_W-1:0]   r_peak;
    logic               r_ovf;

    // snapshot taken when a report starts
    logic [MAG_W-1:0]   r_rep_peak;
    logic [COUNT_W-1:0] r_rep_count;
    logic               r_rep_ovf;

    // thresholds
    logic [THR_W-1:0] r_rms_thr;
    logic [THR_W-1:0] r_peak_thr;

    // output register
    logic r_out_valid;
    t_out r_out;

    logic             w_accept;
    logic             w_is_report;
    logic             w_saturated;
    logic [MAG_W-1:0] w_raw;
    logic [MAG_W-1:0] w_mag;
    logic             w_sq_start;
    logic             w_div_start;
    logic             w_rt_start;
    logic             w_emit;
    logic             w_out_free;
    logic             w_cfg_write;
    logic             w_sq_done;
    logic [SQ_W-1:0]  w_square;
    logic             w_div_done;
    logic [SQ_W-1:0]  w_quotient;
    logic             w_rt_done;
    logic [RT_W-1:0]  w_root;
    logic [31:0]      w_count_ext;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_is_report = i_in_data.req_type == REQ_REPORT;
    assign w_saturated = r_count == COUNT_MAX;

    // magnitude of a two's complement sample; the most negative one gives 2^15 unsigned
    assign w_raw = i_in_data.sample;
    assign w_mag = w_raw[MAG_W-1] ? (~w_raw + 1'b1) : w_raw;

    // the output register can take a new result when empty or being drained
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_is_report) begin
                        n_state = (r_count != '0) ? S_DIVIDE : S_IDLE;
                    end else begin
                        n_state = w_saturated ? S_IDLE : S_SQUARE;
                    end
                end
            end
            S_SQUARE: begin
                if (w_sq_done) n_state = S_IDLE;
            end
            S_DIVIDE: begin
                if (w_div_done) n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_rt_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_sq_start  = 1'b0;
        w_div_start = 1'b0;
        w_rt_start  = 1'b0;
        w_emit      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                w_sq_start  = i_in_valid && !w_is_report && !w_saturated;
                w_div_start = i_in_valid && w_is_report && (r_count != '0);
            end
            S_SQUARE: ;
            S_DIVIDE: begin
                w_rt_start = w_div_done;
            end
            S_ROOT: ;
            S_EMIT: begin
                w_emit = w_out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // accumulators: peak on every sample, sum and count once the square is ready, all cleared by a report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_peak  <= '0;
            r_ovf   <= 1'b0;
        end else if (w_accept && w_is_report) begin
            r_sum   <= '0;
            r_count <= '0;
            r_peak  <= '0;
            r_ovf   <= 1'b0;
        end else if (w_accept) begin
            if (w_mag > r_peak) r_peak <= w_mag;
            if (w_saturated) r_ovf <= 1'b1;
        end else if (r_state == S_SQUARE && w_sq_done) begin
            r_sum   <= r_sum + SUM_W'(w_square);
            r_count <= r_count + 1'b1;
        end
    end

    // snapshot for the report in flight
    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_rep_peak  <= r_peak;
            r_rep_count <= r_count;
            r_rep_ovf   <= r_ovf;
        end
    end

    // threshold registers, unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rms_thr  <= RMS_THR_RESET;
            r_peak_thr <= PEAK_THR_RESET;
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                REG_RMS_THR:  r_rms_thr  <= THR_W'(i_cfg_data);
                REG_PEAK_THR: r_peak_thr <= THR_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // samples_seen carries the whole count
    assign w_count_ext = 32'(r_rep_count);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_out.rms_level      <= w_root;
            r_out.peak_out       <= r_rep_peak;
            r_out.samples_seen   <= w_count_ext[SEEN_W-1:0];
            r_out.active         <= (THR_W'(w_root) >= r_rms_thr)
                                    || (THR_W'(r_rep_peak) >= r_peak_thr);
            r_out.count_overflow <= r_rep_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    arpm_squarer u_squarer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_sq_start),
        .i_mag    (w_mag),
        .o_done   (w_sq_done),
        .o_square (w_square)
    );

    arpm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    arpm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rt_start),
        .i_value (w_quotient),
        .o_done  (w_rt_done),
        .o_root  (w_root)
    );

`ifndef NO_ASSERTIONS
    // the overflow mark only appears once the counter has saturated
    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == COUNT_MAX)
        else $error("overflow mark set below a saturated count");

    // a report in flight always has samples behind it
    a_report_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE || r_state == S_ROOT || r_state == S_EMIT)
        |-> r_rep_count != '0)
        else $error("report in flight with an empty count");

    // the squarer finishes only while the control waits on it
    a_sq_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> r_state == S_SQUARE)
        else $error("squarer finished outside the squaring state");

    // the root unit finishes only while the control waits on it
    a_rt_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rt_done |-> r_state == S_ROOT)
        else $error("square root finished outside the root state");

    // a result entering the output register never overwrites one that is stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> !(r_out_valid && i_out_stall))
        else $error("result written over a stalled transaction");
`endif

endmodule

// ----- design/arpm_squarer.sv -----
// bit-serial squarer: shift-and-add, one multiplier bit per cycle
// depends on arpm_pkg
`timescale 1ns / 1ps

module arpm_squarer
    import arpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_mag,
    output logic             o_done,
    output logic [SQ_W-1:0]  o_square
);

    localparam int CNT_W = $clog2(MAG_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_W-1:0] r_mcand, n_mcand;
    logic [MAG_W-1:0] r_hi, n_hi;
    logic [MAG_W-1:0] r_lo, n_lo;
    logic [MAG_W:0]   w_add;

    // partial sum of the high half plus the multiplicand when the current bit is set
    assign w_add = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_mcand = r_mcand;
        n_hi    = r_hi;
        n_lo    = r_lo;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_mcand = i_mag;
            n_hi    = '0;
            n_lo    = i_mag;
        end else if (r_busy) begin
            n_hi  = w_add[MAG_W:1];
            n_lo  = {w_add[0], r_lo[MAG_W-1:1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_mcand <= n_mcand;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
    end

    assign o_done   = r_done;
    assign o_square = SQ_W'({r_hi, r_lo});

endmodule

// ----- design/arpm_divider.sv -----
// restoring divider, one quotient bit per cycle, dividend shifted out msb first
// depends on arpm_pkg
`timescale 1ns / 1ps

module arpm_divider
    import arpm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SUM_W-1:0]   i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic               o_done,
    output logic [SQ_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SUM_W-1:0]   r_dvd, n_dvd;
    logic [COUNT_W-1:0] r_dvs, n_dvs;
    logic [COUNT_W-1:0] r_rem, n_rem;
    logic [SQ_W-1:0]    r_quo, n_quo;
    logic [COUNT_W:0]   w_trial;
    logic [COUNT_W:0]   w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits the counter width
            n_rem = w_ge ? w_diff[COUNT_W-1:0] : w_trial[COUNT_W-1:0];
            n_dvd = {r_dvd[SUM_W-2:0], 1'b0};
            // quotient never exceeds one square, the upper bits drop off as zeros
            n_quo = {r_quo[SQ_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- design/arpm_isqrt.sv -----
// digit-by-digit integer square root, two radicand bits per cycle
// depends on arpm_pkg
`timescale 1ns / 1ps

module arpm_isqrt
    import arpm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SQ_W-1:0] i_value,
    output logic            o_done,
    output logic [RT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(RT_W);
    localparam int V_W   = 2 * RT_W;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [V_W-1:0]  r_val, n_val;
    logic [RT_W:0]   r_rem, n_rem;
    logic [RT_W-1:0] r_root, n_root;
    logic [RT_W+2:0] w_shift;
    logic [RT_W+2:0] w_trial;
    logic [RT_W+2:0] w_diff;
    logic            w_ge;

    assign w_shift = {r_rem, r_val[V_W-1:V_W-2]};
    assign w_trial = (RT_W + 3)'({r_root, 2'b01});
    assign w_ge    = w_shift >= w_trial;
    assign w_diff  = w_shift - w_trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_val  = V_W'(i_value);
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            // remainder stays at or below twice the partial root
            n_rem  = w_ge ? w_diff[RT_W:0] : w_shift[RT_W:0];
            n_root = {r_root[RT_W-2:0], w_ge};
            n_val  = {r_val[V_W-3:0], 2'b00};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(RT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
